@@ src/dual_motor_pi_speed_control_macros.svh @@
// Assertion macros shared by the speed controller RTL.
`ifndef DUAL_MOTOR_PI_SPEED_CONTROL_MACROS_SVH
`define DUAL_MOTOR_PI_SPEED_CONTROL_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define DMPSC_ASSERT_IMPLIES(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DMPSC_ASSERT_NEXT(name, clk_s, rst_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/dmpsc_pkg.sv @@
// Shared types, constants and register map of the dual motor PI speed controller.
`default_nettype none

package dmpsc_pkg;

  // Input transaction: one sample tick
  typedef struct packed {
    logic signed [15:0] pulses_left;
    logic signed [15:0] pulses_right;
    logic               new_command;
    logic [7:0]         command_value;
    logic [12:0]        distance_mm;
  } in_t;

  // Output transaction: one result per tick
  typedef struct packed {
    logic [7:0] duty_left;
    logic [7:0] duty_right;
    logic       reverse_left;
    logic       reverse_right;
    logic       avoiding;
    logic [7:0] active_command;
  } out_t;

  // Settings seen by each wheel lane
  typedef struct packed {
    logic [11:0] kp;
    logic [11:0] ki;
    logic [9:0]  target;
    logic [17:0] limit;
    logic [7:0]  min_duty;
    logic [7:0]  max_duty;
  } lane_cfg_t;

  // Lane status toward the top level
  typedef struct packed {
    logic       done;
    logic [7:0] duty;
  } lane_stat_t;

  // Integral update request toward the lanes
  typedef struct packed {
    logic commit;
    logic clear;
  } integ_ctl_t;

  // Merged result plus integral action
  typedef struct packed {
    out_t       res;
    integ_ctl_t ctl;
  } merge_t;

  // Drive commands
  localparam logic [7:0] CMD_STOP  = 8'd0;
  localparam logic [7:0] CMD_FWD   = 8'd1;
  localparam logic [7:0] CMD_LEFT  = 8'd2;
  localparam logic [7:0] CMD_REV   = 8'd3;
  localparam logic [7:0] CMD_RIGHT = 8'd4;
  localparam logic [7:0] CMD_AVOID = 8'd5;

  // Configuration register map
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 18;
  localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN      = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN     = 8'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPEED_TARGET   = 8'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 8'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_CMD_TIMEOUT    = 8'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_OBSTACLE_LIMIT = 8'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DUTY       = 8'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DUTY       = 8'd7;

  // Register reset values
  localparam logic [11:0] RST_PROP_GAIN      = 12'd371;
  localparam logic [11:0] RST_INTEG_GAIN     = 12'd192;
  localparam logic [9:0]  RST_SPEED_TARGET   = 10'd175;
  localparam logic [17:0] RST_INTEGRAL_LIMIT = 18'd59733;
  localparam logic [7:0]  RST_CMD_TIMEOUT    = 8'd2;
  localparam logic [12:0] RST_OBSTACLE_LIMIT = 13'd120;
  localparam logic [7:0]  RST_MIN_DUTY       = 8'd75;
  localparam logic [7:0]  RST_MAX_DUTY       = 8'd250;

  // Spin-turn duty and tick counter ceiling
  localparam logic [7:0] SPIN_DUTY = 8'd190;
  localparam logic [7:0] TICKS_MAX = 8'd255;

  // rpm_q8 = |p| * 1200 * 256 / 186 = |p| * 51200 / 31 = 1651 |p| + 19 |p| / 31
  localparam logic [10:0] RPM_INT      = 11'd1651;
  localparam logic [4:0]  RPM_FRAC_NUM = 5'd19;
  // floor(y / 31) for y < 2^20
  localparam logic [20:0] DIV31_MUL    = 21'd1082402;
  // floor(z / 5) for z < 2^24
  localparam logic [24:0] DIV5_MUL     = 25'd26843546;

endpackage

`default_nettype wire

@@ src/dmpsc_lane.sv @@
// One wheel lane: speed from encoder count, PI loop with clamped integral, duty.
`default_nettype none
`include "dual_motor_pi_speed_control_macros.svh"

module dmpsc_lane (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     start,
  input  wire signed [15:0]       pulses,
  input  dmpsc_pkg::lane_cfg_t    cfg,
  input  dmpsc_pkg::integ_ctl_t   ctl,
  output dmpsc_pkg::lane_stat_t   stat
);
  import dmpsc_pkg::*;

  localparam logic [3:0] LastStep = 4'd8;

  // Sequencer and integral state
  logic        running;
  logic [3:0]  step;
  logic        done;
  logic [17:0] integ;

  // Datapath registers, written by the steps
  logic [16:0]        abs_p;
  logic [25:0]        base;
  logic [19:0]        frac_num;
  logic [14:0]        frac_q;
  logic signed [26:0] err;
  logic               err_neg;
  logic [23:0]        err_quarter;
  logic [21:0]        step_q;
  logic [17:0]        i_new;
  logic signed [39:0] kp_prod;
  logic [29:0]        ki_prod;
  logic signed [41:0] pwm_acc;
  logic [7:0]         duty;

  // Combinational helpers
  logic [16:0]        p_ext;
  logic [40:0]        div31_prod;
  logic [25:0]        rpm;
  logic [26:0]        err_mag;
  logic [48:0]        div5_prod;
  logic signed [23:0] integ_sum;
  logic [17:0]        integ_clamped;
  logic signed [39:0] kp_ext;
  logic signed [39:0] err_ext;
  logic [25:0]        duty_wide;
  logic [7:0]         duty_clamped;

  assign p_ext      = {pulses[15], pulses};
  assign div31_prod = 41'(frac_num) * 41'(DIV31_MUL);
  assign rpm        = base + 26'(frac_q);
  assign err_mag    = err_neg ? 27'(-err) : 27'(err);
  assign div5_prod  = 49'(err_quarter) * 49'(DIV5_MUL);
  assign kp_ext     = 40'(signed'({1'b0, cfg.kp}));
  assign err_ext    = 40'(err);

  // Integral step (error / 20, toward zero) and clamp to 0..limit
  always_comb begin
    if (err_neg) begin
      integ_sum = signed'({6'b0, integ}) - signed'({2'b0, step_q});
    end else begin
      integ_sum = signed'({6'b0, integ}) + signed'({2'b0, step_q});
    end
    if (integ_sum[23]) begin
      integ_clamped = '0;
    end else if (integ_sum[22:0] > {5'b0, cfg.limit}) begin
      integ_clamped = cfg.limit;
    end else begin
      integ_clamped = integ_sum[17:0];
    end
  end

  // Duty: min_duty on a negative sum, then limited to max_duty
  always_comb begin
    if (pwm_acc[41]) begin
      duty_wide = 26'(cfg.min_duty);
    end else begin
      duty_wide = pwm_acc[41:16];
    end
    if (duty_wide > 26'(cfg.max_duty)) begin
      duty_clamped = cfg.max_duty;
    end else begin
      duty_clamped = duty_wide[7:0];
    end
  end

  // Sequencer and integral register
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      step    <= '0;
      done    <= 1'b0;
      integ   <= '0;
    end else begin
      done <= !start && running && (step == LastStep);
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        if (step == LastStep) begin
          running <= 1'b0;
        end
        step <= 4'(step + 4'd1);
      end
      if (ctl.clear) begin
        integ <= '0;
      end else if (ctl.commit) begin
        integ <= i_new;
      end
    end
  end

  // Datapath steps
  always_ff @(posedge clk) begin
    if (start) begin
      abs_p <= p_ext[16] ? 17'(-p_ext) : p_ext;
    end
    if (running) begin
      unique case (step)
        4'd0: begin
          base     <= 26'(26'(abs_p) * 26'(RPM_INT));
          frac_num <= 20'(20'(abs_p) * 20'(RPM_FRAC_NUM));
        end
        4'd1: frac_q <= div31_prod[39:25];
        4'd2: begin
          err     <= signed'({9'b0, cfg.target, 8'b0}) - signed'({1'b0, rpm});
          err_neg <= 1'b0;
        end
        4'd3: begin
          err_neg     <= err[26];
          err_quarter <= err[26] ? 24'(27'(-err) >> 2) : 24'(err >>> 2);
        end
        4'd4: step_q  <= div5_prod[48:27];
        4'd5: i_new   <= integ_clamped;
        4'd6: begin
          kp_prod <= 40'(kp_ext * err_ext);
          ki_prod <= 30'(cfg.ki) * 30'(i_new);
        end
        4'd7: pwm_acc <= 42'(kp_prod) + 42'(signed'({1'b0, ki_prod}))
                         + 42'(signed'({1'b0, cfg.min_duty, 16'b0}));
        4'd8: duty    <= duty_clamped;
        default: ;
      endcase
    end
  end

  assign stat.done = done;
  assign stat.duty = duty;

  // err_mag feeds the quarter computation check below
  `DMPSC_ASSERT_IMPLIES(a_start_idle, clk, rst, start, !running, "lane started while busy")
  `DMPSC_ASSERT_IMPLIES(a_done_seq, clk, rst, done, $past(running) && !running, "stray lane done")
  `DMPSC_ASSERT_NEXT(a_commit_bound, clk, rst, ctl.commit, integ <= cfg.limit, "integral above limit")
  `DMPSC_ASSERT_IMPLIES(a_quarter, clk, rst, running && step == 4'd4, err_quarter == err_mag[25:2], "error magnitude mismatch")

endmodule

`default_nettype wire

@@ src/dmpsc_merge.sv @@
// Merges both lane duties with the command and obstacle rules into one result.
`default_nettype none

module dmpsc_merge (
  input  wire                 avoid,
  input  wire  [7:0]          cmd,
  input  wire  [7:0]          duty_left,
  input  wire  [7:0]          duty_right,
  input  wire  [7:0]          max_duty,
  input  wire                 dir_left_rev,
  input  wire                 dir_right_rev,
  output dmpsc_pkg::merge_t   merged
);
  import dmpsc_pkg::*;

  logic [7:0] spin_duty;

  assign spin_duty = (max_duty < SPIN_DUTY) ? max_duty : SPIN_DUTY;

  // Command decode; stop and every other undecoded command clear both integrals and keep the pins
  always_comb begin
    merged.res.active_command = cmd;
    merged.res.avoiding       = avoid;
    merged.res.duty_left      = '0;
    merged.res.duty_right     = '0;
    merged.res.reverse_left   = dir_left_rev;
    merged.res.reverse_right  = dir_right_rev;
    merged.ctl.commit         = 1'b0;
    merged.ctl.clear          = 1'b0;
    if (avoid) begin
      merged.res.duty_left     = spin_duty;
      merged.res.duty_right    = spin_duty;
      merged.res.reverse_left  = 1'b1;
      merged.res.reverse_right = 1'b0;
    end else begin
      unique case (cmd)
        CMD_FWD: begin
          merged.res.duty_left     = duty_left;
          merged.res.duty_right    = duty_right;
          merged.res.reverse_left  = 1'b0;
          merged.res.reverse_right = 1'b0;
          merged.ctl.commit        = 1'b1;
        end
        CMD_REV: begin
          merged.res.duty_left     = duty_left;
          merged.res.duty_right    = duty_right;
          merged.res.reverse_left  = 1'b1;
          merged.res.reverse_right = 1'b1;
          merged.ctl.commit        = 1'b1;
        end
        CMD_LEFT: begin
          merged.res.duty_left     = duty_left;
          merged.res.reverse_left  = 1'b0;
          merged.res.reverse_right = 1'b0;
          merged.ctl.commit        = 1'b1;
        end
        CMD_RIGHT: begin
          merged.res.duty_right    = duty_right;
          merged.res.reverse_left  = 1'b0;
          merged.res.reverse_right = 1'b0;
          merged.ctl.commit        = 1'b1;
        end
        default: merged.ctl.clear = 1'b1;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ src/dual_motor_pi_speed_control.sv @@
// Top level of the dual motor PI speed controller.
`default_nettype none
`include "dual_motor_pi_speed_control_macros.svh"

// Dual motor PI speed controller. Each sample transaction carries both encoder
// counts, an optional drive command and the obstacle distance; it yields one
// result transaction with both duties, direction pins, the avoidance flag and
// the command in force. Two identical wheel lanes run side by side and a merge
// stage applies the command and obstacle rules. A transaction runs
// through the nine-step lane sequence (speed conversion, two reciprocal
// divides, integral clamp, gain products, duty clamp) and result capture; no
// new sample is accepted until its lanes are done and the result is loaded.
// A new sample is taken while an earlier result still waits on result_stall,
// but its result is held until the output register frees. Configuration
// writes are always ready and take effect at once, also mid-transaction.
module dual_motor_pi_speed_control (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   sample_valid,
  output logic                                  sample_stall,
  input  dmpsc_pkg::in_t                        sample,
  output logic                                  result_valid,
  input  wire                                   result_stall,
  output dmpsc_pkg::out_t                       result,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [dmpsc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [dmpsc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import dmpsc_pkg::*;

  typedef enum logic [1:0] {IDLE, RUN, HOLD} state_t;

  // Configuration registers
  logic [11:0] prop_gain;
  logic [11:0] integ_gain;
  logic [9:0]  speed_target;
  logic [17:0] integral_limit;
  logic [7:0]  command_timeout_ticks;
  logic [12:0] obstacle_limit_mm;
  logic [7:0]  min_duty;
  logic [7:0]  max_duty;

  // Control state
  state_t      state;
  logic [7:0]  held_command;
  logic [7:0]  ticks_since_cmd;
  logic        avoid;
  logic        dir_left_rev;
  logic        dir_right_rev;

  // Accept-time command logic
  logic        accept;
  logic [7:0]  cmd_taken;
  logic [7:0]  ticks_taken;
  logic [7:0]  cmd_live;
  logic        obstacle;
  logic [7:0]  held_command_next;
  logic [7:0]  ticks_since_cmd_next;

  logic        out_free;
  logic        load;

  lane_cfg_t   lane_cfg;
  integ_ctl_t  lane_ctl;
  lane_stat_t  stat_left;
  lane_stat_t  stat_right;
  merge_t      merged;

  assign cfg_ready    = 1'b1;
  assign sample_stall = (state != IDLE);
  assign accept       = sample_valid && !sample_stall;
  assign out_free     = !result_valid || !result_stall;
  assign load         = out_free && ((state == RUN && stat_left.done) || state == HOLD);

  // Configuration write port
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain             <= RST_PROP_GAIN;
      integ_gain            <= RST_INTEG_GAIN;
      speed_target          <= RST_SPEED_TARGET;
      integral_limit        <= RST_INTEGRAL_LIMIT;
      command_timeout_ticks <= RST_CMD_TIMEOUT;
      obstacle_limit_mm     <= RST_OBSTACLE_LIMIT;
      min_duty              <= RST_MIN_DUTY;
      max_duty              <= RST_MAX_DUTY;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PROP_GAIN:      prop_gain             <= cfg_data[11:0];
        REG_INTEG_GAIN:     integ_gain            <= cfg_data[11:0];
        REG_SPEED_TARGET:   speed_target          <= cfg_data[9:0];
        REG_INTEGRAL_LIMIT: integral_limit        <= cfg_data[17:0];
        REG_CMD_TIMEOUT:    command_timeout_ticks <= cfg_data[7:0];
        REG_OBSTACLE_LIMIT: obstacle_limit_mm     <= cfg_data[12:0];
        REG_MIN_DUTY:       min_duty              <= cfg_data[7:0];
        REG_MAX_DUTY:       max_duty              <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Command intake, timeout and obstacle override
  always_comb begin
    cmd_taken   = sample.new_command ? sample.command_value : held_command;
    ticks_taken = sample.new_command ? '0 : ticks_since_cmd;
    cmd_live    = (ticks_taken > command_timeout_ticks) ? CMD_STOP : cmd_taken;
    obstacle    = (sample.distance_mm != '0) && (sample.distance_mm <= obstacle_limit_mm);
    held_command_next    = obstacle ? CMD_AVOID : cmd_live;
    ticks_since_cmd_next = (ticks_taken == TICKS_MAX) ? TICKS_MAX : 8'(ticks_taken + 8'd1);
  end

  assign lane_cfg = '{kp: prop_gain, ki: integ_gain, target: speed_target,
                      limit: integral_limit, min_duty: min_duty, max_duty: max_duty};
  assign lane_ctl.commit = load && merged.ctl.commit;
  assign lane_ctl.clear  = load && merged.ctl.clear;

  dmpsc_lane u_lane_left (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .pulses (sample.pulses_left),
    .cfg    (lane_cfg),
    .ctl    (lane_ctl),
    .stat   (stat_left)
  );

  dmpsc_lane u_lane_right (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .pulses (sample.pulses_right),
    .cfg    (lane_cfg),
    .ctl    (lane_ctl),
    .stat   (stat_right)
  );

  dmpsc_merge u_merge (
    .avoid         (avoid),
    .cmd           (held_command),
    .duty_left     (stat_left.duty),
    .duty_right    (stat_right.duty),
    .max_duty      (max_duty),
    .dir_left_rev  (dir_left_rev),
    .dir_right_rev (dir_right_rev),
    .merged        (merged)
  );

  // Sequencer, held command and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      held_command    <= CMD_STOP;
      ticks_since_cmd <= TICKS_MAX;
      avoid           <= 1'b0;
      dir_left_rev    <= 1'b0;
      dir_right_rev   <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            held_command    <= held_command_next;
            ticks_since_cmd <= ticks_since_cmd_next;
            avoid           <= obstacle;
            state           <= RUN;
          end
        end
        RUN: begin
          if (stat_left.done) begin
            state <= out_free ? IDLE : HOLD;
          end
        end
        HOLD: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
      if (load) begin
        result        <= merged.res;
        result_valid  <= 1'b1;
        dir_left_rev  <= merged.res.reverse_left;
        dir_right_rev <= merged.res.reverse_right;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  `DMPSC_ASSERT_IMPLIES(a_lanes_lockstep, clk, rst, stat_left.done || stat_right.done, stat_left.done && stat_right.done, "lanes out of step")
  `DMPSC_ASSERT_IMPLIES(a_load_free, clk, rst, load, !result_valid || !result_stall, "result overwritten")
  `DMPSC_ASSERT_IMPLIES(a_avoid_cmd, clk, rst, result_valid && result.avoiding, result.active_command == CMD_AVOID, "avoid without avoid command")
  `DMPSC_ASSERT_NEXT(a_accept_runs, clk, rst, accept, state == RUN && sample_stall, "accepted sample not started")

endmodule

`default_nettype wire
